### rtl/btes_pkg.sv
package btes_pkg;

    localparam int DIGITS = 8;

    localparam logic [2:0] NAV_NONE       = 3'd7;
    localparam logic [2:0] NAV_WAIT_TICKS = 3'd5;
    localparam logic [4:0] VIB_HOLD_TICKS = 5'd18;
    localparam logic [3:0] DECADE_LAST    = 4'd9;

    typedef enum logic [2:0] {
        CFG_SCAN_BEGIN   = 3'd0,
        CFG_SCAN_END     = 3'd1,
        CFG_SEGMENTS     = 3'd2,
        CFG_LED_PATTERN  = 3'd3,
        CFG_HALL_ENABLE  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DRIVE_NONE  = 2'd0,
        DRIVE_DIGIT = 2'd1,
        DRIVE_LED   = 2'd2
    } t_drive_kind;

    typedef struct packed {
        logic       press;
        logic [2:0] press_code;
        logic       release_ev;
        logic [2:0] release_code;
    } t_nav_event;

endpackage

### rtl/btes_nav.sv
module btes_nav (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [2:0]            i_nav_level,
    output btes_pkg::t_nav_event  o_event
);
    import btes_pkg::*;

    logic [2:0] r_held_code;
    logic [2:0] n_held_code;
    logic [2:0] r_wait;
    logic [2:0] n_wait;
    logic [2:0] wait_dec;
    logic       pressed;
    logic       held;

    assign pressed  = (i_nav_level != NAV_NONE);
    assign held     = (r_held_code != NAV_NONE);
    assign wait_dec = r_wait - 3'd1;

    always_comb begin
        n_held_code = r_held_code;
        n_wait      = r_wait;
        o_event     = '0;
        if (pressed && !held) begin
            if (r_wait != 3'd0) begin
                n_wait = wait_dec;
                if (wait_dec == 3'd0) begin
                    o_event.press      = 1'b1;
                    o_event.press_code = i_nav_level;
                    n_held_code        = i_nav_level;
                end
            end else begin
                n_wait = NAV_WAIT_TICKS;
            end
        end else if (!pressed && held) begin
            o_event.release_ev   = 1'b1;
            o_event.release_code = r_held_code;
            n_held_code          = NAV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_code <= NAV_NONE;
            r_wait      <= 3'd0;
        end else if (i_step) begin
            r_held_code <= n_held_code;
            r_wait      <= n_wait;
        end
    end

endmodule

### rtl/board_tick_event_scanner.sv
// The result word for a tick is registered and appears on the output in the cycle after it is accepted.
// Throughput: one tick word per cycle while i_out_ready is not holding the output; the output register
// is refilled in the same cycle that its word is taken.
// Reset: synchronous, active low; it clears the configuration registers, the debounce, scan, hall,
// vibration and period state, and the output valid.
module board_tick_event_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_nav_level,
    input  logic        i_hall_pin,
    input  logic        i_vib_pin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_drive_kind,
    output logic [2:0]  o_digit_select,
    output logic [7:0]  o_drive_byte,
    output logic        o_nav_press,
    output logic [2:0]  o_nav_press_code,
    output logic        o_nav_release,
    output logic [2:0]  o_nav_release_code,
    output logic        o_hall_edge,
    output logic        o_hall_level,
    output logic        o_vib_start,
    output logic [2:0]  o_period_events
);
    import btes_pkg::*;

    logic [3:0]  r_scan_begin;
    logic [3:0]  r_scan_end;
    logic [63:0] r_segments;
    logic [7:0]  r_led_pattern;
    logic [1:0]  r_hall_enable;

    logic [3:0]  r_scan_index;
    logic [3:0]  n_scan_index;
    logic        r_hall_last;
    logic [4:0]  r_vib_hold;
    logic [4:0]  n_vib_hold;
    logic [3:0]  r_ones;
    logic [3:0]  r_tens;
    logic [3:0]  r_hundreds;
    logic [3:0]  n_ones;
    logic [3:0]  n_tens;
    logic [3:0]  n_hundreds;

    logic        accept;
    t_nav_event  nav_event;

    t_drive_kind n_drive_kind;
    logic [2:0]  n_digit_select;
    logic [7:0]  n_drive_byte;
    logic        n_hall_edge;
    logic        n_hall_level;
    logic        n_vib_start;
    logic [2:0]  n_period_events;

    logic        r_out_valid;
    logic [1:0]  r_drive_kind;
    logic [2:0]  r_digit_select;
    logic [7:0]  r_drive_byte;
    t_nav_event  r_nav_event;
    logic        r_hall_edge;
    logic        r_hall_level;
    logic        r_vib_start;
    logic [2:0]  r_period_events;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_begin  <= 4'd0;
            r_scan_end    <= 4'd0;
            r_segments    <= 64'd0;
            r_led_pattern <= 8'd0;
            r_hall_enable <= 2'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SCAN_BEGIN:  r_scan_begin  <= i_cfg_wdata[3:0];
                CFG_SCAN_END:    r_scan_end    <= i_cfg_wdata[3:0];
                CFG_SEGMENTS:    r_segments    <= i_cfg_wdata;
                CFG_LED_PATTERN: r_led_pattern <= i_cfg_wdata[7:0];
                CFG_HALL_ENABLE: r_hall_enable <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    btes_nav u_nav (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_nav_level (i_nav_level),
        .o_event     (nav_event)
    );

    always_comb begin
        n_drive_kind   = DRIVE_NONE;
        n_digit_select = 3'd0;
        n_drive_byte   = 8'd0;
        n_scan_index   = r_scan_index;
        if (r_scan_index < r_scan_end) begin
            if (r_scan_index < 4'(DIGITS)) begin
                n_drive_kind   = DRIVE_DIGIT;
                n_digit_select = r_scan_index[2:0];
                n_drive_byte   = r_segments[{r_scan_index[2:0], 3'b000} +: 8];
            end
            n_scan_index = r_scan_index + 4'd1;
        end else begin
            n_drive_kind = DRIVE_LED;
            n_drive_byte = r_led_pattern;
            n_scan_index = r_scan_begin;
        end
    end

    always_comb begin
        n_hall_edge  = 1'b0;
        n_hall_level = 1'b0;
        if (r_hall_last != i_hall_pin && r_hall_enable[i_hall_pin]) begin
            n_hall_edge  = 1'b1;
            n_hall_level = i_hall_pin;
        end
    end

    always_comb begin
        n_vib_start = 1'b0;
        n_vib_hold  = r_vib_hold;
        if (!i_vib_pin) begin
            n_vib_start = (r_vib_hold == 5'd0);
            n_vib_hold  = VIB_HOLD_TICKS;
        end else if (r_vib_hold != 5'd0) begin
            n_vib_hold = r_vib_hold - 5'd1;
        end
    end

    // The period phase is kept as three decimal digits, so the boundaries are zero tests.
    always_comb begin
        n_period_events[0] = (r_ones == 4'd0);
        n_period_events[1] = n_period_events[0] && (r_tens == 4'd0);
        n_period_events[2] = n_period_events[1] && (r_hundreds == 4'd0);
        n_ones     = r_ones + 4'd1;
        n_tens     = r_tens;
        n_hundreds = r_hundreds;
        if (r_ones == DECADE_LAST) begin
            n_ones = 4'd0;
            n_tens = r_tens + 4'd1;
            if (r_tens == DECADE_LAST) begin
                n_tens     = 4'd0;
                n_hundreds = r_hundreds + 4'd1;
                if (r_hundreds == DECADE_LAST) begin
                    n_hundreds = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_index <= 4'd0;
            r_hall_last  <= 1'b1;
            r_vib_hold   <= 5'd0;
            r_ones       <= 4'd0;
            r_tens       <= 4'd0;
            r_hundreds   <= 4'd0;
        end else if (accept) begin
            r_scan_index <= n_scan_index;
            r_hall_last  <= i_hall_pin;
            r_vib_hold   <= n_vib_hold;
            r_ones       <= n_ones;
            r_tens       <= n_tens;
            r_hundreds   <= n_hundreds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_kind    <= n_drive_kind;
            r_digit_select  <= n_digit_select;
            r_drive_byte    <= n_drive_byte;
            r_nav_event     <= nav_event;
            r_hall_edge     <= n_hall_edge;
            r_hall_level    <= n_hall_level;
            r_vib_start     <= n_vib_start;
            r_period_events <= n_period_events;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_kind       = r_drive_kind;
    assign o_digit_select     = r_digit_select;
    assign o_drive_byte       = r_drive_byte;
    assign o_nav_press        = r_nav_event.press;
    assign o_nav_press_code   = r_nav_event.press_code;
    assign o_nav_release      = r_nav_event.release_ev;
    assign o_nav_release_code = r_nav_event.release_code;
    assign o_hall_edge        = r_hall_edge;
    assign o_hall_level       = r_hall_level;
    assign o_vib_start        = r_vib_start;
    assign o_period_events    = r_period_events;

endmodule
